>>> rtl/mmrd_pkg.sv
package mmrd_pkg;

	// width of the decimation factor register
	localparam int FACTOR_W = 13;

	// default build values
	localparam int MAX_FACTOR_DEF  = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// reset value of the factor register
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

endpackage

>>> rtl/mmrd_front.sv
module mmrd_front import mmrd_pkg::*; #(
	parameter int MAX_FACTOR  = MAX_FACTOR_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(MAX_FACTOR + 1),
	parameter int SUM_W       = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FACTOR),
	parameter int REC_W       = 2 * SAMPLE_BITS + SUM_W + CNT_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [FACTOR_W-1:0]           cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [REC_W-1:0]              q_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int CMP_W = (CNT_W > FACTOR_W) ? CNT_W : FACTOR_W;

	localparam logic signed [SB-1:0] MIN_INIT = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] MAX_INIT = {1'b1, {(SB-1){1'b0}}};

	logic [FACTOR_W-1:0]  factor_q;
	logic [CNT_W-1:0]     count_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic [SUM_W-1:0]     sum_q;

	logic [CMP_W-1:0]        fac_ext;
	logic [CMP_W-1:0]        fac_eff;
	logic [CMP_W-1:0]        cnt_next;
	logic signed [2*SB-1:0]  sq;
	logic signed [SB-1:0]    min_next;
	logic signed [SB-1:0]    max_next;
	logic [SUM_W-1:0]        sum_next;
	logic                    accept;
	logic                    close;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		fac_ext = CMP_W'(factor_q);
		if (fac_ext == '0) begin
			fac_eff = CMP_W'(1);
		end else if (fac_ext > CMP_W'(MAX_FACTOR)) begin
			fac_eff = CMP_W'(MAX_FACTOR);
		end else begin
			fac_eff = fac_ext;
		end
	end

	assign cnt_next = CMP_W'(count_q) + CMP_W'(1);
	assign close    = cnt_next >= fac_eff;

	assign sq       = sample * sample;
	assign min_next = (sample < min_q) ? sample : min_q;
	assign max_next = (sample > max_q) ? sample : max_q;
	// square is never negative, so its bits read as unsigned
	assign sum_next = sum_q + SUM_W'($unsigned(sq));

	assign q_push = accept && close;
	assign q_data = {min_next, max_next, sum_next, cnt_next[CNT_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			count_q  <= '0;
			min_q    <= MIN_INIT;
			max_q    <= MAX_INIT;
			sum_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				factor_q <= cfg_wr_data;
			end
			if (accept) begin
				if (close) begin
					count_q <= '0;
					min_q   <= MIN_INIT;
					max_q   <= MAX_INIT;
					sum_q   <= '0;
				end else begin
					count_q <= cnt_next[CNT_W-1:0];
					min_q   <= min_next;
					max_q   <= max_next;
					sum_q   <= sum_next;
				end
			end
		end
	end

endmodule

>>> rtl/mmrd_queue.sv
module mmrd_queue import mmrd_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	output logic             rd_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data
);

	// two-entry queue between accumulation and the divide/root engine
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign full     = fill_q == 2'd2;
	assign rd_valid = fill_q != 2'd0;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/mmrd_back.sv
module mmrd_back import mmrd_pkg::*; #(
	parameter int MAX_FACTOR  = MAX_FACTOR_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(MAX_FACTOR + 1),
	parameter int SUM_W       = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FACTOR),
	parameter int REC_W       = 2 * SAMPLE_BITS + SUM_W + CNT_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic [REC_W-1:0]              q_data,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] min_value,
	output logic signed [SAMPLE_BITS-1:0] max_value,
	output logic [SAMPLE_BITS-1:0]        rms_value
);

	localparam int SB     = SAMPLE_BITS;
	localparam int RAD_W  = 2 * SB;
	localparam int RR_W   = SB + 2;
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_HOLD
	} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [SB-1:0] gmin_q;
	logic signed [SB-1:0] gmax_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [CNT_W-1:0]     rem_q;
	logic [RAD_W-1:0]     rad_q;
	logic [RR_W-1:0]      rr_q;
	logic [SB-1:0]        root_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic [SB-1:0]        rms_q;

	logic [CNT_W:0]   rem_sh;
	logic             qbit;
	logic [CNT_W-1:0] rem_nx;
	logic [RR_W+1:0]  rr_sh;
	logic [RR_W+1:0]  trial;
	logic             rbit;
	logic [RR_W+1:0]  rr_diff;
	logic             out_free;

	// restoring divide: one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
	assign qbit   = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = qbit ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];

	// digit-by-digit square root: two radicand bits per cycle
	assign rr_sh   = {rr_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = (RR_W + 2)'({root_q, 2'b01});
	assign rbit    = rr_sh >= trial;
	assign rr_diff = rr_sh - trial;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	assign out_valid = out_valid_q;
	assign min_value = min_q;
	assign max_value = max_q;
	assign rms_value = rms_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				{gmin_q, gmax_q, dvd_q, dvs_q} <= q_data;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[SUM_W-2:0], qbit};
				rr_q   <= '0;
				root_q <= '0;
				// quotient never exceeds the largest square, so RAD_W bits hold it
				if (step_q == STEP_W'(SUM_W - 1)) begin
					rad_q <= {dvd_q[RAD_W-2:0], qbit};
				end
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rr_q   <= rbit ? rr_diff[RR_W-1:0] : rr_sh[RR_W-1:0];
				root_q <= {root_q[SB-2:0], rbit};
			end
			ST_HOLD: begin
			end
			default: begin
			end
		endcase
		if (state_q == ST_HOLD && out_free) begin
			min_q <= gmin_q;
			max_q <= gmax_q;
			rms_q <= root_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (q_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(SUM_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(SB - 1)) begin
						step_q  <= '0;
						state_q <= ST_HOLD;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/min_max_rms_decimator.sv
// channel   signals                              transfer when
// --------  -----------------------------------  ---------------------------
// config    cfg_wr_en, cfg_wr_data               cfg_wr_en high
// input     in_valid, in_ready, sample           in_valid && in_ready
// output    out_valid, out_ready,                out_valid && out_ready
//           min_value, max_value, rms_value
//
// Samples are taken one per cycle while in_ready is high; a closed group goes
// into a two-entry queue. The back end takes one group at a time: first a
// one-bit-per-cycle divide by the sample count, then a two-bits-per-cycle root.
// in_ready drops only while the queue is full; the result register frees the
// engine as soon as out_ready takes the previous result. Reset clears all
// control state and sets the factor to 1.
module min_max_rms_decimator import mmrd_pkg::*; #(
	parameter int MAX_FACTOR  = MAX_FACTOR_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [FACTOR_W-1:0]           cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] min_value,
	output logic signed [SAMPLE_BITS-1:0] max_value,
	output logic [SAMPLE_BITS-1:0]        rms_value
);

	localparam int CNT_W = $clog2(MAX_FACTOR + 1);
	localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FACTOR);
	localparam int REC_W = 2 * SAMPLE_BITS + SUM_W + CNT_W;

	logic             q_full;
	logic             q_push;
	logic [REC_W-1:0] q_wr_data;
	logic             q_valid;
	logic             q_pop;
	logic [REC_W-1:0] q_rd_data;

	mmrd_front #(
		.MAX_FACTOR  (MAX_FACTOR),
		.SAMPLE_BITS (SAMPLE_BITS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W),
		.REC_W       (REC_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	mmrd_queue #(
		.WIDTH (REC_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.rd_valid (q_valid),
		.pop      (q_pop),
		.rd_data  (q_rd_data)
	);

	mmrd_back #(
		.MAX_FACTOR  (MAX_FACTOR),
		.SAMPLE_BITS (SAMPLE_BITS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W),
		.REC_W       (REC_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_rd_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.min_value (min_value),
		.max_value (max_value),
		.rms_value (rms_value)
	);

endmodule
